>>> src/fsb_pkg.sv
// Shared types, codes and constants of the flush scheduler.
`default_nettype none

package fsb_pkg;

  // Default width of the time base in milliseconds.
  localparam int TIME_BITS_DEF = 48;

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int TIME_IN_W = 48;
  localparam int PEND_W  = 16;
  localparam int RES_W   = 2;
  localparam int WAIT_W  = 48;
  localparam int DLY_W   = 32;
  localparam int IVS_W   = 17;
  localparam int THR_W   = 16;
  localparam int IVMS_W  = 27;             // seconds times 1000 fits in 27 bits
  localparam int JIT_W   = DLY_W + 1;      // jittered delay stays below 1.25 * 2^32
  localparam int DSR_W   = DLY_W - 1;      // 2 * quarter + 1 fits in 31 bits
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // Register reset values.
  localparam logic             ENABLE_RST   = 1'b1;
  localparam logic [IVS_W-1:0] IVS_RST      = 17'd30;
  localparam logic [THR_W-1:0] THR_RST      = 16'd20;
  localparam logic [DLY_W-1:0] INIT_MS_RST  = 32'd1000;
  localparam logic [DLY_W-1:0] MAX_MS_RST   = 32'd60000;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 2'd0,
    FN_DONE  = 2'd1,
    FN_ENQ   = 2'd2,
    FN_START = 2'd3
  } func_t;

  typedef enum logic [RES_W-1:0] {
    RES_OK    = 2'd0,
    RES_RETRY = 2'd1,
    RES_FATAL = 2'd2
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_INTERVAL  = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_RETRY_INIT = 3'd3,
    CFG_RETRY_MAX = 3'd4
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic div_init;
    logic div_step;
    logic jit_calc;
    logic update;
    logic out_load;
  } fsb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_retry;
    logic q_zero;
    logic div_last;
  } fsb_status_t;

endpackage

`default_nettype wire

>>> src/fsb_in_if.sv
// Input event channel of the flush scheduler.
`default_nettype none

interface fsb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [47:0] now_ms;
  logic [15:0] queue_len;
  logic [1:0]  flush_result;

  modport source (output valid, output func, output now_ms, output queue_len,
                  output flush_result, input ready);
  modport sink (input valid, input func, input now_ms, input queue_len,
                input flush_result, output ready);
endinterface

`default_nettype wire

>>> src/fsb_out_if.sv
// Result channel of the flush scheduler.
`default_nettype none

interface fsb_out_if;
  logic        valid;
  logic        ready;
  logic        flush_now;
  logic [47:0] wait_ms;
  logic        wait_forever;
  logic [31:0] backoff_ms;

  modport source (output valid, output flush_now, output wait_ms, output wait_forever,
                  output backoff_ms, input ready);
  modport sink (input valid, input flush_now, input wait_ms, input wait_forever,
                input backoff_ms, output ready);
endinterface

`default_nettype wire

>>> src/fsb_ctrl.sv
// Sequencing controller of the flush scheduler.
`default_nettype none

module fsb_ctrl
  import fsb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire fsb_status_t status,
  output fsb_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_JIT,
    S_UPD,
    S_DEC
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.load_item = in_valid && in_ready_r;
      S_PREP: cmd.div_init  = 1'b1;
      S_DIV:  cmd.div_step  = 1'b1;
      S_JIT:  cmd.jit_calc  = 1'b1;
      S_UPD:  cmd.update    = 1'b1;
      S_DEC:  cmd.out_load  = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_PREP;
            in_ready_r <= 1'b0;
          end
        end
        S_PREP: begin
          if (!status.is_retry) begin
            state_r <= S_UPD;
          end else if (status.q_zero) begin
            state_r <= S_JIT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (status.div_last) begin
            state_r <= S_JIT;
          end
        end
        S_JIT: state_r <= S_UPD;
        S_UPD: state_r <= S_DEC;
        S_DEC: begin
          if (cmd.out_load) begin
            state_r     <= S_IDLE;
            in_ready_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready_r) |=> !in_ready_r)
    else $error("ready stayed high after an accepted word");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == S_IDLE))
    else $error("ready raised outside idle");

  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DEC))
    else $error("result word raised outside decide step");

  a_div_only_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (status.is_retry && !status.q_zero))
    else $error("jitter division running without a retryable failure");
`endif

endmodule

`default_nettype wire

>>> src/fsb_dp.sv
// Datapath of the flush scheduler: registers, jitter divider and decision logic.
`default_nettype none

module fsb_dp
  import fsb_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [TIME_IN_W-1:0]  in_now_ms,
  input  wire logic [PEND_W-1:0]     in_queue_len,
  input  wire logic [RES_W-1:0]      in_flush_result,
  input  wire fsb_cmd_t              cmd,
  output fsb_status_t                status,
  output logic                       out_flush_now,
  output logic [WAIT_W-1:0]          out_wait_ms,
  output logic                       out_wait_forever,
  output logic [DLY_W-1:0]           out_backoff_ms
);

  localparam int TW    = TIME_BITS;
  localparam int SUM_W = TW + 2;
  localparam int CNT_W = $clog2(TW);
  localparam int WX    = (TW > WAIT_W) ? TW : WAIT_W;

  // Configuration.
  logic              en_r;
  logic [IVS_W-1:0]  ivs_r;
  logic [THR_W-1:0]  thr_r;
  logic [DLY_W-1:0]  init_r;
  logic [DLY_W-1:0]  max_r;
  logic [IVMS_W-1:0] iv_ms_r;

  // Captured event.
  logic [FUNC_W-1:0] func_r;
  logic [TW-1:0]     now_r;
  logic [PEND_W-1:0] pend_r;
  logic [RES_W-1:0]  res_r;

  // Scheduler state.
  logic [DLY_W-1:0] backoff_r;
  logic [TW-1:0]    rd_r;
  logic [TW-1:0]    id_r;
  logic             fp_r;

  // Jitter divider.
  logic [TW-1:0]    dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [JIT_W-1:0] jit_r;

  // Result word.
  logic              flush_r;
  logic [WAIT_W-1:0] wait_r;
  logic              forever_r;
  logic [DLY_W-1:0]  bo_out_r;

  function automatic logic [TW-1:0] add_sat(input logic [TW-1:0] a,
                                            input logic [JIT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {2'b00, a} + SUM_W'(b);
    add_sat = (s[SUM_W-1:TW] != 2'b00) ? '1 : s[TW-1:0];
  endfunction

  function automatic logic [WAIT_W-1:0] sat_wait(input logic [TW-1:0] w);
    logic [WX-1:0] wx;
    wx = WX'(w);
    sat_wait = (wx > WX'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(wx);
  endfunction

  // Delay in use for the next retry and its quarter.
  logic [DLY_W-1:0]   delay;
  logic [DLY_W-3:0]   quarter;
  assign delay   = (backoff_r != '0) ? backoff_r : init_r;
  assign quarter = delay[DLY_W-1:2];

  // Restoring division step: one dividend bit per cycle.
  logic [DSR_W:0]   trial;
  logic [DSR_W-1:0] rem_nxt;
  assign trial   = {rem_r, dvd_r[TW-1]};
  assign rem_nxt = (trial >= {1'b0, dsr_r}) ? DSR_W'(trial - {1'b0, dsr_r})
                                            : trial[DSR_W-1:0];

  // Backoff growth, clamped to the ceiling.
  logic [DLY_W-1:0] ceil_ms;
  logic [DLY_W:0]   grow;
  logic [DLY_W-1:0] backoff_grow;
  assign ceil_ms      = (max_r < init_r) ? init_r : max_r;
  assign grow         = (backoff_r == '0) ? {1'b0, init_r} : {backoff_r, 1'b0};
  assign backoff_grow = (grow > {1'b0, ceil_ms}) ? ceil_ms : grow[DLY_W-1:0];

  logic iv_on;
  logic thr_hit;
  assign iv_on   = (ivs_r != '0);
  assign thr_hit = (thr_r != '0) && (pend_r >= thr_r);

  // Decision on the updated state.
  logic [TW:0] diff_rd;
  logic [TW:0] diff_id;
  logic        rd_gt;
  logic        id_gt;
  logic        due;
  logic        fire;
  assign diff_rd = {1'b0, rd_r} - {1'b0, now_r};
  assign diff_id = {1'b0, id_r} - {1'b0, now_r};
  assign rd_gt   = !diff_rd[TW] && (diff_rd[TW-1:0] != '0);
  assign id_gt   = !diff_id[TW] && (diff_id[TW-1:0] != '0);
  assign due     = iv_on && !id_gt;
  assign fire    = en_r && (func_r == FN_TICK) && (fp_r || due) && !rd_gt;

  logic              flush_nxt;
  logic [WAIT_W-1:0] wait_nxt;
  logic              forever_nxt;

  always_comb begin
    flush_nxt   = 1'b0;
    wait_nxt    = '0;
    forever_nxt = 1'b0;
    priority if (!en_r) begin
      forever_nxt = 1'b1;
    end else if (fire) begin
      flush_nxt = 1'b1;
    end else if (rd_gt) begin
      wait_nxt = sat_wait(diff_rd[TW-1:0]);
    end else if (fp_r) begin
      wait_nxt = '0;
    end else if (iv_on) begin
      wait_nxt = id_gt ? sat_wait(diff_id[TW-1:0]) : '0;
    end else begin
      forever_nxt = 1'b1;
    end
  end

  assign status.is_retry = (func_r == FN_DONE) && (res_r == RES_RETRY);
  assign status.q_zero   = (quarter == '0);
  assign status.div_last = (cnt_r == CNT_W'(TW - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= ENABLE_RST;
      ivs_r  <= IVS_RST;
      thr_r  <= THR_RST;
      init_r <= INIT_MS_RST;
      max_r  <= MAX_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:     en_r   <= cfg_data[0];
        CFG_INTERVAL:   ivs_r  <= cfg_data[IVS_W-1:0];
        CFG_THRESHOLD:  thr_r  <= cfg_data[THR_W-1:0];
        CFG_RETRY_INIT: init_r <= cfg_data[DLY_W-1:0];
        CFG_RETRY_MAX:  max_r  <= cfg_data[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    iv_ms_r <= IVMS_W'(ivs_r) * IVMS_W'(MS_PER_S);
  end

  // Event capture, divider and jitter.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_func;
      now_r  <= TW'(in_now_ms);
      pend_r <= in_queue_len;
      res_r  <= in_flush_result;
    end
    if (cmd.div_init) begin
      dvd_r <= now_r;
      dsr_r <= {quarter, 1'b1};
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[TW-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.jit_calc) begin
      jit_r <= status.q_zero ? {1'b0, delay}
                             : {1'b0, delay} - JIT_W'(quarter) + JIT_W'(rem_r);
    end
  end

  // Scheduler state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r <= '0;
      rd_r      <= '0;
      id_r      <= '0;
      fp_r      <= 1'b0;
    end else if (cmd.update) begin
      unique case (func_r)
        FN_START: begin
          if (en_r) begin
            backoff_r <= init_r;
            if (iv_on) begin
              id_r <= add_sat(now_r, JIT_W'(iv_ms_r));
            end
            if (thr_r != '0) begin
              fp_r <= thr_hit;
            end
          end
        end
        FN_ENQ: begin
          if (en_r && thr_hit) begin
            fp_r <= 1'b1;
          end
        end
        FN_DONE: begin
          if (res_r == RES_OK) begin
            backoff_r <= init_r;
            rd_r      <= '0;
          end else if (res_r == RES_RETRY) begin
            rd_r      <= add_sat(now_r, jit_r);
            fp_r      <= 1'b1;
            backoff_r <= backoff_grow;
          end
          if (iv_on) begin
            id_r <= add_sat(now_r, JIT_W'(iv_ms_r));
          end
        end
        default: ;
      endcase
    end else if (cmd.out_load && fire) begin
      fp_r <= 1'b0;
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      flush_r   <= flush_nxt;
      wait_r    <= wait_nxt;
      forever_r <= forever_nxt;
      bo_out_r  <= backoff_r;
    end
  end

  assign out_flush_now    = flush_r;
  assign out_wait_ms      = wait_r;
  assign out_wait_forever = forever_r;
  assign out_backoff_ms   = bo_out_r;

endmodule

`default_nettype wire

>>> src/flush_scheduler_with_backoff_core.sv
// Top level of the flush scheduler with exponential retry backoff and jitter.
//
// Usage: every input word is one event (tick, flush done, enqueued, start)
// stamped with the current millisecond time. Every event gives exactly one
// result word: flush now, the wait until the next decision (or wait forever)
// and the backoff delay after the event.
// Channels: in_ch and out_ch move words by valid/ready; a word moves at a
// rising edge with both high. The cfg port writes one register per cycle with
// cfg_we high; write it only while no event is in flight.
// Steps: each accepted event is captured and then updated into the scheduler
// state, and its result word is decided. A retryable flush failure first
// computes the jitter remainder (now modulo twice the quarter delay plus one)
// with a restoring divider that retires one dividend bit per cycle, or skips
// the divider when the quarter is zero. in_ch.ready rises again as a result is
// loaded; a new event is accepted only after the last one's result is loaded.
// Stall: the result register holds its word until out_ch.ready; a new event
// is accepted meanwhile, and its result waits in the decide step.
// Reset: rst_n (synchronous, active low) restores register defaults, clears
// backoff, both deadlines and the pending flush, and empties the result slot.
`default_nettype none

module flush_scheduler_with_backoff_core
  import fsb_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  fsb_in_if.sink                     in_ch,
  fsb_out_if.source                  out_ch
);

  fsb_cmd_t    cmd;
  fsb_status_t status;

  // Sequencer: owns the handshakes and walks each event through its steps.
  fsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: configuration, scheduler state, divider and the result word.
  fsb_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_func          (in_ch.func),
    .in_now_ms        (in_ch.now_ms),
    .in_queue_len     (in_ch.queue_len),
    .in_flush_result  (in_ch.flush_result),
    .cmd              (cmd),
    .status           (status),
    .out_flush_now    (out_ch.flush_now),
    .out_wait_ms      (out_ch.wait_ms),
    .out_wait_forever (out_ch.wait_forever),
    .out_backoff_ms   (out_ch.backoff_ms)
  );

endmodule

`default_nettype wire
